### hdl/phc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phc_pkg: shared types and constants for pixel_to_hex_cube
// Fixed-point widths, the sqrt(3) constant and the divider lane record.
// ----------------------------------------------------------------------------
package phc_pkg;

    localparam int PIX_W  = 24;  // pixel coordinate, signed Q15.8
    localparam int SIZE_W = 16;  // hex size, unsigned Q8.8
    localparam int CUBE_W = 16;  // cube coordinate, signed integer
    localparam int PROD_W = 58;  // signed numerator width
    localparam int NUM_W  = 59;  // dividend 2*|N| + D
    localparam int QUO_W  = 15;  // rounded quotient magnitude
    localparam int D_W    = 50;  // D = 3 * size * 2^32
    localparam int DIV_W  = 51;  // divisor 2 * D
    localparam int SUM_W  = 18;  // width for rebuilding one coordinate

    // sqrt(3) in Q32, rounded
    localparam logic [32:0] SQRT3_Q32 = 33'd7439101574;
    // sizes below 1.0 are treated as 1.0
    localparam logic [SIZE_W-1:0] SIZE_MIN = 16'd256;

    typedef struct packed {
        logic             neg;  // sign of the numerator
        logic [NUM_W-1:0] rem;  // partial remainder
        logic [QUO_W-1:0] quo;  // quotient bits found so far
    } lane_t;

    typedef struct packed {
        lane_t q;
        lane_t r;
        lane_t s;
    } div_item_t;

endpackage

### hdl/phc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phc_front: numerator formation
// Two stages: sqrt(3) product and sums, then magnitude and dividend setup.
// ----------------------------------------------------------------------------
module phc_front (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             en,
    input  logic                             in_valid,
    input  logic signed [phc_pkg::PIX_W-1:0] pixel_x,
    input  logic signed [phc_pkg::PIX_W-1:0] pixel_y,
    input  logic [phc_pkg::D_W-1:0]          d_val,
    output logic                             out_valid,
    output phc_pkg::div_item_t               out_item
);
    import phc_pkg::*;

    logic                     v1_reg;
    logic signed [PROD_W-1:0] nq_reg, nr_reg;
    logic signed [PROD_W-1:0] prod, nq_next, nr_next, ns;
    logic                     v2_reg;
    div_item_t                item_reg, item_next;

    function automatic lane_t make_lane(input logic signed [PROD_W-1:0] v,
                                        input logic [D_W-1:0] d);
        logic [PROD_W-1:0] mag;
        lane_t             l;
        mag   = v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
        l.neg = v[PROD_W-1];
        l.rem = NUM_W'({mag[PROD_W-2:0], 1'b0}) + NUM_W'(d);
        l.quo = '0;
        return l;
    endfunction

    // form the q and r numerators
    always_comb begin
        prod    = $signed({1'b0, SQRT3_Q32}) * pixel_x;
        nq_next = prod + $signed({{2{pixel_y[PIX_W-1]}}, pixel_y, 32'b0});
        nr_next = -$signed({pixel_y[PIX_W-1], pixel_y, 33'b0});
    end

    // rounding setup: dividend 2*|N| + D for each lane
    always_comb begin
        ns          = -nq_reg - nr_reg;
        item_next.q = make_lane(nq_reg, d_val);
        item_next.r = make_lane(nr_reg, d_val);
        item_next.s = make_lane(ns, d_val);
    end

    // advance both stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
        if (en) begin
            nq_reg   <= nq_next;
            nr_reg   <= nr_next;
            item_reg <= item_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_item  = item_reg;

endmodule

### hdl/phc_div_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phc_div_step: one restoring division step
// Resolves one quotient bit on all three lanes and registers the result.
// ----------------------------------------------------------------------------
module phc_div_step #(
    parameter int SHIFT = 0
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      in_valid,
    input  phc_pkg::div_item_t        in_item,
    input  logic [phc_pkg::DIV_W-1:0] div_val,
    output logic                      out_valid,
    output phc_pkg::div_item_t        out_item
);
    import phc_pkg::*;

    localparam int WIDE_W = NUM_W + QUO_W;

    logic      valid_reg;
    div_item_t item_reg, item_next;

    function automatic lane_t step(input lane_t a, input logic [DIV_W-1:0] b);
        logic [WIDE_W-1:0] sh;
        lane_t             o;
        sh = WIDE_W'(b) << SHIFT;
        o  = a;
        if (WIDE_W'(a.rem) >= sh) begin
            o.rem        = a.rem - sh[NUM_W-1:0];
            o.quo[SHIFT] = 1'b1;
        end
        return o;
    endfunction

    // trial subtract on each lane
    always_comb begin
        item_next.q = step(in_item.q, div_val);
        item_next.r = step(in_item.r, div_val);
        item_next.s = step(in_item.s, div_val);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
        if (en) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

### hdl/phc_select.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phc_select: cube rounding fix-up and output register
// Rebuilds the coordinate with the largest rounding error and saturates.
// ----------------------------------------------------------------------------
module phc_select (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_valid,
    input  phc_pkg::div_item_t                in_item,
    input  logic [phc_pkg::D_W-1:0]           d_val,
    output logic                              out_valid,
    output logic signed [phc_pkg::CUBE_W-1:0] cube_q,
    output logic signed [phc_pkg::CUBE_W-1:0] cube_r,
    output logic signed [phc_pkg::CUBE_W-1:0] cube_s
);
    import phc_pkg::*;

    localparam int ERR_W = D_W + 3;

    logic                     valid_reg;
    logic signed [CUBE_W-1:0] q_reg, r_reg, s_reg;
    logic signed [SUM_W-1:0]  kq, kr, ks;
    logic [ERR_W-1:0]         eq, er, es;

    function automatic logic signed [SUM_W-1:0] signed_k(input lane_t l);
        logic signed [SUM_W-1:0] k;
        k = $signed(SUM_W'(l.quo));
        return l.neg ? -k : k;
    endfunction

    // twice the rounding error, scaled by D: |D - remainder|
    function automatic logic [ERR_W-1:0] round_err(input lane_t l,
                                                   input logic [D_W-1:0] d);
        logic [ERR_W-1:0] rem, dd;
        rem = l.rem[ERR_W-1:0];
        dd  = ERR_W'(d);
        return (rem >= dd) ? rem - dd : dd - rem;
    endfunction

    function automatic logic signed [CUBE_W-1:0] sat(input logic signed [SUM_W-1:0] v);
        if (v > $signed(SUM_W'(16'sh7FFF))) begin
            return 16'sh7FFF;
        end else if (v < -$signed(SUM_W'(17'h08000))) begin
            return 16'sh8000;
        end
        return v[CUBE_W-1:0];
    endfunction

    // rebuild the worst component; ties with s go to s, a tie of q and r goes to r
    always_comb begin
        kq = signed_k(in_item.q);
        kr = signed_k(in_item.r);
        ks = signed_k(in_item.s);
        eq = round_err(in_item.q, d_val);
        er = round_err(in_item.r, d_val);
        es = round_err(in_item.s, d_val);
        if (eq > er && eq > es) begin
            kq = -kr - ks;
        end else if (er > es) begin
            kr = -kq - ks;
        end else begin
            ks = -kq - kr;
        end
    end

    // hold the result until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
        if (en) begin
            q_reg <= sat(kq);
            r_reg <= sat(kr);
            s_reg <= sat(ks);
        end
    end

    assign out_valid = valid_reg;
    assign cube_q    = q_reg;
    assign cube_r    = r_reg;
    assign cube_s    = s_reg;

endmodule

### hdl/pixel_to_hex_cube.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_to_hex_cube: pixel position to pointy-top hex cube coordinates
// Fully pipelined, one request per cycle unless the output is held.
// ----------------------------------------------------------------------------
// Accepts one pixel request every cycle and returns one cube coordinate
// triple per request, in order, through eighteen register stages: two stages
// form the exact numerators, fifteen restoring divider stages (one quotient
// bit each, all three coordinates in parallel) divide by 3*size, and one
// stage rebuilds the coordinate with the largest rounding error and registers
// the output. The whole pipeline stalls together when the output is held, so
// throughput is one result per cycle while m_ready stays high. Write
// cfg_wdata only while no request is in flight.
module pixel_to_hex_cube (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [phc_pkg::SIZE_W-1:0]        cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [phc_pkg::PIX_W-1:0]  s_pixel_x,
    input  logic signed [phc_pkg::PIX_W-1:0]  s_pixel_y,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [phc_pkg::CUBE_W-1:0] m_cube_q,
    output logic signed [phc_pkg::CUBE_W-1:0] m_cube_r,
    output logic signed [phc_pkg::CUBE_W-1:0] m_cube_s
);
    import phc_pkg::*;

    logic [SIZE_W-1:0]  hex_size_reg;
    logic [SIZE_W-1:0]  h_eff;
    logic [SIZE_W+1:0]  h3;
    logic [D_W-1:0]     d_val;
    logic [DIV_W-1:0]   div_val;
    logic               en;
    logic               front_valid;
    div_item_t          front_item;
    logic [QUO_W:0]     stage_valid;
    div_item_t          stage_item [QUO_W+1];

    // size register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hex_size_reg <= SIZE_MIN;
        end else if (cfg_we) begin
            hex_size_reg <= cfg_wdata;
        end
    end

    // clamp size and derive D and 2*D
    always_comb begin
        h_eff   = (hex_size_reg < SIZE_MIN) ? SIZE_MIN : hex_size_reg;
        h3      = (SIZE_W+2)'({h_eff, 1'b0}) + (SIZE_W+2)'(h_eff);
        d_val   = {h3, 32'b0};
        div_val = {h3, 33'b0};
    end

    // advance the whole pipeline unless the output is held
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    phc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .pixel_x   (s_pixel_x),
        .pixel_y   (s_pixel_y),
        .d_val     (d_val),
        .out_valid (front_valid),
        .out_item  (front_item)
    );

    assign stage_valid[0] = front_valid;
    assign stage_item[0]  = front_item;

    for (genvar j = 0; j < QUO_W; j++) begin : g_div
        phc_div_step #(
            .SHIFT (QUO_W - 1 - j)
        ) u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (stage_valid[j]),
            .in_item   (stage_item[j]),
            .div_val   (div_val),
            .out_valid (stage_valid[j+1]),
            .out_item  (stage_item[j+1])
        );
    end

    phc_select u_select (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (stage_valid[QUO_W]),
        .in_item   (stage_item[QUO_W]),
        .d_val     (d_val),
        .out_valid (m_valid),
        .cube_q    (m_cube_q),
        .cube_r    (m_cube_r),
        .cube_s    (m_cube_s)
    );

    // cube constraint holds on every result
    a_cube_sum : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (SUM_W'(m_cube_q) + SUM_W'(m_cube_r) + SUM_W'(m_cube_s)) == '0
                    || ($signed(SUM_W'(m_cube_q)) + $signed(SUM_W'(m_cube_r))
                        + $signed(SUM_W'(m_cube_s))) == '0)
        else $error("cube coordinates do not sum to zero");

    // reset empties the pipeline
    a_reset_empty : assert property (@(posedge aclk)
        !aresetn |=> !m_valid && stage_valid[QUO_W:1] == '0)
        else $error("pipeline not empty after reset");

    // a request in the last divider step leaves the divider when the pipeline advances
    a_div_flow : assert property (@(posedge aclk) disable iff (!aresetn)
        en && stage_valid[QUO_W-1] |=> stage_valid[QUO_W])
        else $error("divider lost a request");

endmodule

### tb/hex_cube_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hex_cube_checker: result predictor and scoreboard for pixel_to_hex_cube
// Watches both handshakes, computes the expected cube coordinates with exact
// fraction arithmetic for every accepted request and compares them in order.
// ----------------------------------------------------------------------------
module hex_cube_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [phc_pkg::SIZE_W-1:0]        cfg_wdata,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  logic signed [phc_pkg::PIX_W-1:0]  s_pixel_x,
    input  logic signed [phc_pkg::PIX_W-1:0]  s_pixel_y,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  logic signed [phc_pkg::CUBE_W-1:0] m_cube_q,
    input  logic signed [phc_pkg::CUBE_W-1:0] m_cube_r,
    input  logic signed [phc_pkg::CUBE_W-1:0] m_cube_s,
    output int                                fail_count,
    output int                                pending_count
);
    import phc_pkg::*;

    typedef struct packed {
        logic signed [CUBE_W-1:0] q;
        logic signed [CUBE_W-1:0] r;
        logic signed [CUBE_W-1:0] s;
    } cube_t;

    logic [SIZE_W-1:0] size_reg;
    cube_t             cube_queue[$];

    // n / d rounded half away from zero, d > 0
    function automatic longint round_away(longint n, longint d);
        longint mag;
        longint k;
        mag = (n < 0) ? -n : n;
        k   = (2 * mag + d) / (2 * d);
        return (n < 0) ? -k : k;
    endfunction

    function automatic longint abs_err(longint k, longint n, longint d);
        longint e;
        e = k * d - n;
        return (e < 0) ? -e : e;
    endfunction

    function automatic logic signed [CUBE_W-1:0] clamp16(longint v);
        if (v > 32767)
            return 16'sh7fff;
        if (v < -32768)
            return 16'sh8000;
        return v[CUBE_W-1:0];
    endfunction

    // pixel position to hex cube coordinates at the current size
    function automatic cube_t pixel_to_cube(longint x, longint y, logic [SIZE_W-1:0] sz);
        longint eff, d, nq, nr, ns, q, r, s, eq, er, es;
        cube_t  res;
        eff = (sz < SIZE_MIN) ? longint'(SIZE_MIN) : longint'(sz);
        d   = 3 * eff * (64'sd1 <<< 32);
        nq  = 64'sd7439101574 * x + y * (64'sd1 <<< 32);
        nr  = -2 * y * (64'sd1 <<< 32);
        ns  = -nq - nr;
        q   = round_away(nq, d);
        r   = round_away(nr, d);
        s   = round_away(ns, d);
        eq  = abs_err(q, nq, d);
        er  = abs_err(r, nr, d);
        es  = abs_err(s, ns, d);
        if (eq > er && eq > es)
            q = -r - s;
        else if (er > es)
            r = -q - s;
        else
            s = -q - r;
        res.q = clamp16(q);
        res.r = clamp16(r);
        res.s = clamp16(s);
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    assign pending_count = cube_queue.size();

    initial fail_count = 0;

    // track size, predict on accept, compare on result
    always @(posedge aclk) begin
        cube_t want;
        if (!aresetn) begin
            size_reg <= 16'd256;
        end else begin
            if (cfg_we)
                size_reg <= cfg_wdata;
            if (s_valid && s_ready)
                cube_queue.push_back(pixel_to_cube(s_pixel_x, s_pixel_y, size_reg));
            if (m_valid && m_ready) begin
                if (cube_queue.size() == 0) begin
                    $display("unexpected result at %0t", $realtime);
                    fail_count++;
                end else begin
                    want = cube_queue.pop_front();
                    if (m_cube_q !== want.q)
                        report_mismatch("cube_q", m_cube_q, want.q);
                    if (m_cube_r !== want.r)
                        report_mismatch("cube_r", m_cube_r, want.r);
                    if (m_cube_s !== want.s)
                        report_mismatch("cube_s", m_cube_s, want.s);
                end
            end
        end
    end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for pixel_to_hex_cube
// Drives pixel requests over several hex sizes with random gaps and output
// stalls, including one long stall; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb;
    import phc_pkg::*;

    localparam int LATENCY   = 18;
    localparam int CYCLE_CAP = 400000;

    logic                     aclk;
    logic                     aresetn;
    logic                     cfg_we;
    logic [SIZE_W-1:0]        cfg_wdata;
    logic                     s_valid;
    logic                     s_ready;
    logic signed [PIX_W-1:0]  s_pixel_x;
    logic signed [PIX_W-1:0]  s_pixel_y;
    logic                     m_valid;
    logic                     m_ready;
    logic signed [CUBE_W-1:0] m_cube_q;
    logic signed [CUBE_W-1:0] m_cube_r;
    logic signed [CUBE_W-1:0] m_cube_s;
    int                       fail_count;
    int                       pending_count;
    int                       cycle_count;
    bit                       calm_phase;
    bit                       long_hold;

    pixel_to_hex_cube u_top (.*);

    hex_cube_checker u_chk (.*);

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // watchdog
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count > CYCLE_CAP) begin
                $display("timeout");
                $display("tb NOT OK");
                $finish;
            end
        end
    end

    // receiver: random stall bursts, one long hold, none at the end
    initial begin
        int n;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (long_hold) begin
                m_ready <= 1'b0;
                repeat (200) @(negedge aclk);
                long_hold = 1'b0;
            end else if (!calm_phase && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 16);
                m_ready <= 1'b0;
                repeat (n - 1) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // offer one request, after a random gap outside the calm phase, and hold it until accepted
    task automatic send_pixel(logic [PIX_W-1:0] x, logic [PIX_W-1:0] y);
        int n;
        if (!calm_phase && $urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 16);
            s_valid <= 1'b0;
            repeat (n) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_pixel_x <= x;
        s_pixel_y <= y;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic drain_and_write(logic [SIZE_W-1:0] sz);
        s_valid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (LATENCY + 2) @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= sz;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [PIX_W-1:0] rand_pixel();
        case ($urandom_range(0, 3))
            0: return PIX_W'($urandom_range(0, 4095) - 2048);
            1: return PIX_W'($urandom_range(0, 1 << 16) - (1 << 15));
            default: return PIX_W'($urandom());
        endcase
    endfunction

    initial begin
        logic [SIZE_W-1:0] sizes[6];
        calm_phase = 1'b0;
        long_hold  = 1'b0;
        aresetn    = 1'b0;
        cfg_we     = 1'b0;
        cfg_wdata  = '0;
        s_valid    = 1'b0;
        s_pixel_x  = '0;
        s_pixel_y  = '0;
        sizes = '{16'd0, 16'd256, 16'd65535, 16'd100, 16'd2560, 16'd384};
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // edge values at reset size
        send_pixel(24'h000000, 24'h000000);
        send_pixel(24'h7fffff, 24'h7fffff);
        send_pixel(24'h800000, 24'h800000);
        send_pixel(24'h7fffff, 24'h800000);
        send_pixel(24'h800000, 24'h7fffff);
        send_pixel(24'hffffff, 24'h000001);
        send_pixel(24'h000080, 24'h000000);
        send_pixel(24'hffff80, 24'h000000);
        send_pixel(24'h000000, 24'h000180);
        send_pixel(24'h000000, 24'hfffe80);
        send_pixel(24'h555555, 24'haaaaaa);
        send_pixel(24'haaaaaa, 24'h555555);

        // fill the pipe against a long output hold
        long_hold = 1'b1;
        repeat (40) send_pixel(rand_pixel(), rand_pixel());

        for (int p = 0; p < 6; p++) begin
            drain_and_write(sizes[p]);
            if (p == 5)
                calm_phase = 1'b1;
            send_pixel(24'h7fffff, 24'h800000);
            send_pixel(24'h000180, 24'hfffe80);
            repeat (60) send_pixel(rand_pixel(), rand_pixel());
        end
        s_valid <= 1'b0;

        while (pending_count != 0) @(negedge aclk);
        repeat (LATENCY + 4) @(negedge aclk);
        if (fail_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
